// ===== design/adlc_pkg.sv =====
package adlc_pkg;

  localparam logic [7:0] NEWLINE     = 8'd10;
  localparam logic [7:0] SPACE       = 8'h20;
  localparam logic [7:0] DIGIT_ZERO  = 8'h30;
  localparam logic [7:0] UPPER_A     = 8'h41;
  localparam logic [7:0] UPPER_Z     = 8'h5a;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam int COUNT_WIDTH = 32;
  localparam int DIGITS      = 10;
  localparam int MIN_DIGITS  = 7;
  localparam int CHUNK_BYTES = 8;

  localparam logic [0:0] REG_COUNT_MODE  = 1'b0;
  localparam logic [0:0] REG_IGNORE_CASE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_CMP,
    ST_START,
    ST_CONV,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_PREFIX,
    PH_LINE,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic wr_byte;
    logic cmp_start;
    logic take;
    logic bump;
    logic clear;
    logic conv_start;
    logic emit_start;
    logic emit_last;
  } cmd_t;

  typedef struct packed {
    logic len_eq;
    logic cmp_busy;
    logic cmp_equal;
    logic conv_done;
    logic emit_busy;
    logic seen;
    logic cur_len_nz;
    logic count_mode;
  } status_t;

endpackage

// ===== design/adlc_ctrl.sv =====
module adlc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              text_valid,
  input  logic [7:0]        text_byte,
  input  logic              end_of_input,
  input  adlc_pkg::status_t st,
  output logic              stall,
  output adlc_pkg::cmd_t    cmd
);

  adlc_pkg::state_t state, state_next;
  logic eoi, eoi_next;
  logic final_emit, final_emit_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= adlc_pkg::ST_IDLE;
      eoi        <= 1'b0;
      final_emit <= 1'b0;
    end else begin
      state      <= state_next;
      eoi        <= eoi_next;
      final_emit <= final_emit_next;
    end
  end

  always_comb begin
    state_next      = state;
    eoi_next        = eoi;
    final_emit_next = final_emit;
    case (state)
      adlc_pkg::ST_IDLE: begin
        if (text_valid) begin
          if (end_of_input) begin
            eoi_next        = 1'b1;
            final_emit_next = 1'b0;
            if (st.cur_len_nz) begin
              state_next = adlc_pkg::ST_CLOSE;
            end else if (st.seen) begin
              final_emit_next = 1'b1;
              state_next      = adlc_pkg::ST_START;
            end
          end else if (text_byte == adlc_pkg::NEWLINE) begin
            eoi_next        = 1'b0;
            final_emit_next = 1'b0;
            state_next      = adlc_pkg::ST_CLOSE;
          end
        end
      end
      adlc_pkg::ST_CLOSE: begin
        if (!st.seen) begin
          final_emit_next = eoi;
          state_next      = eoi ? adlc_pkg::ST_START : adlc_pkg::ST_IDLE;
        end else if (st.len_eq) begin
          state_next = adlc_pkg::ST_CMP;
        end else begin
          state_next = adlc_pkg::ST_START;
        end
      end
      adlc_pkg::ST_CMP: begin
        if (!st.cmp_busy) begin
          if (st.cmp_equal) begin
            final_emit_next = eoi;
            state_next      = eoi ? adlc_pkg::ST_START : adlc_pkg::ST_IDLE;
          end else begin
            state_next = adlc_pkg::ST_START;
          end
        end
      end
      adlc_pkg::ST_START: begin
        state_next = st.count_mode ? adlc_pkg::ST_CONV : adlc_pkg::ST_EMIT;
      end
      adlc_pkg::ST_CONV: begin
        if (st.conv_done) state_next = adlc_pkg::ST_EMIT;
      end
      adlc_pkg::ST_EMIT: begin
        if (!st.emit_busy) begin
          if (final_emit) begin
            state_next = adlc_pkg::ST_IDLE;
          end else if (eoi) begin
            // differing line flushed, now the held line goes out
            final_emit_next = 1'b1;
            state_next      = adlc_pkg::ST_START;
          end else begin
            state_next = adlc_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = adlc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.emit_last = final_emit || !eoi;
    stall         = (state != adlc_pkg::ST_IDLE);
    case (state)
      adlc_pkg::ST_IDLE: begin
        cmd.wr_byte = text_valid && !end_of_input && (text_byte != adlc_pkg::NEWLINE);
        cmd.clear   = text_valid && end_of_input && !st.cur_len_nz && !st.seen;
      end
      adlc_pkg::ST_CLOSE: begin
        cmd.take      = !st.seen;
        cmd.cmp_start = st.seen && st.len_eq;
      end
      adlc_pkg::ST_CMP: begin
        cmd.bump = !st.cmp_busy && st.cmp_equal;
      end
      adlc_pkg::ST_START: begin
        cmd.conv_start = st.count_mode;
        cmd.emit_start = !st.count_mode;
      end
      adlc_pkg::ST_CONV: begin
        cmd.emit_start = st.conv_done;
      end
      adlc_pkg::ST_EMIT: begin
        cmd.clear = !st.emit_busy && final_emit;
        cmd.take  = !st.emit_busy && !final_emit;
      end
      default: ;
    endcase
  end

endmodule

// ===== design/adlc_dp.sv =====
module adlc_dp #(
  parameter int LINE_BYTES = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [0:0]        wr_index,
  input  logic [0:0]        wr_data,
  input  logic [7:0]        text_byte,
  input  adlc_pkg::cmd_t    cmd,
  output adlc_pkg::status_t st,
  output logic              chunk_valid,
  input  logic              chunk_stall,
  output logic [63:0]       chunk,
  output logic [3:0]        chunk_bytes,
  output logic              line_end,
  output logic              last
);

  localparam int AW = (LINE_BYTES > 2) ? $clog2(LINE_BYTES) : 1;
  localparam int PW = (AW > 4) ? AW : 4;
  localparam logic [AW-1:0] MAX_LEN = AW'(LINE_BYTES - 1);

  function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
    logic [7:0] r;
    r = c;
    if (ic && c >= adlc_pkg::UPPER_A && c <= adlc_pkg::UPPER_Z) r = c + adlc_pkg::CASE_OFFSET;
    return r;
  endfunction

  logic count_mode, ignore_case;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_mode  <= 1'b0;
      ignore_case <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        adlc_pkg::REG_COUNT_MODE:  count_mode  <= wr_data[0];
        adlc_pkg::REG_IGNORE_CASE: ignore_case <= wr_data[0];
        default: ;
      endcase
    end
  end

  // two line banks; the current line fills one, the held line sits in the other
  logic [7:0] mem0 [LINE_BYTES];
  logic [7:0] mem1 [LINE_BYTES];
  logic [7:0] rd0, rd1;
  logic [AW-1:0] rd_addr;
  logic cur_bank;
  logic [AW-1:0] cur_len, held_len;
  logic [adlc_pkg::COUNT_WIDTH-1:0] run_count;
  logic seen;
  logic do_write;

  assign do_write = cmd.wr_byte && (cur_len < MAX_LEN);

  always_ff @(posedge clk) begin
    if (do_write && !cur_bank) mem0[cur_len] <= text_byte;
    rd0 <= mem0[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (do_write && cur_bank) mem1[cur_len] <= text_byte;
    rd1 <= mem1[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_bank  <= 1'b0;
      cur_len   <= '0;
      held_len  <= '0;
      run_count <= '0;
      seen      <= 1'b0;
    end else if (cmd.clear) begin
      cur_len   <= '0;
      held_len  <= '0;
      run_count <= '0;
      seen      <= 1'b0;
    end else if (cmd.take) begin
      cur_bank  <= ~cur_bank;
      held_len  <= cur_len;
      run_count <= adlc_pkg::COUNT_WIDTH'(1);
      seen      <= 1'b1;
      cur_len   <= '0;
    end else if (cmd.bump) begin
      if (run_count != '1) run_count <= run_count + 1'b1;
      cur_len <= '0;
    end else if (do_write) begin
      cur_len <= cur_len + 1'b1;
    end
  end

  logic [7:0] cur_rd, prev_rd;
  assign cur_rd  = cur_bank ? rd1 : rd0;
  assign prev_rd = cur_bank ? rd0 : rd1;

  // compare walk: one address per cycle, data checked from the registered read
  logic [AW-1:0] cmp_idx;
  logic cmp_active, cmp_pend, cmp_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_active <= 1'b0;
      cmp_pend   <= 1'b0;
      cmp_diff   <= 1'b0;
      cmp_idx    <= '0;
    end else if (cmd.cmp_start) begin
      cmp_active <= 1'b1;
      cmp_pend   <= 1'b0;
      cmp_diff   <= 1'b0;
      cmp_idx    <= '0;
    end else begin
      cmp_pend <= cmp_active && (cmp_idx != cur_len);
      if (cmp_active) begin
        if (cmp_idx == cur_len) cmp_active <= 1'b0;
        else cmp_idx <= cmp_idx + 1'b1;
      end
      if (cmp_pend && (fold(cur_rd, ignore_case) != fold(prev_rd, ignore_case)))
        cmp_diff <= 1'b1;
    end
  end

  // binary to decimal, one shift-and-adjust per cycle
  logic [adlc_pkg::COUNT_WIDTH-1:0] conv_bin;
  logic [4*adlc_pkg::DIGITS-1:0] bcd, bcd_adj;
  logic [5:0] conv_cnt;
  logic conv_done;

  assign conv_done = (conv_cnt == 6'(adlc_pkg::COUNT_WIDTH));

  always_comb begin
    for (int i = 0; i < adlc_pkg::DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.conv_start) begin
      conv_bin <= run_count;
      bcd      <= '0;
      conv_cnt <= '0;
    end else if (!conv_done) begin
      {bcd, conv_bin} <= {bcd_adj[4*adlc_pkg::DIGITS-2:0], conv_bin, 1'b0};
      conv_cnt        <= conv_cnt + 1'b1;
    end
  end

  logic [3:0] num_digits, field_w;
  always_comb begin
    num_digits = 4'd1;
    for (int i = 0; i < adlc_pkg::DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) num_digits = 4'(i + 1);
    end
    field_w = (num_digits > 4'(adlc_pkg::MIN_DIGITS)) ? num_digits : 4'(adlc_pkg::MIN_DIGITS);
  end

  // byte generator feeding the chunk packer
  adlc_pkg::phase_t phase;
  logic [PW-1:0] gen_pos;
  logic gen_active, emit_last;
  logic b_vld, b_mem, b_final;
  logic [7:0] b_byte;
  logic [3:0] pack_cnt;
  logic pack_final;
  logic [63:0] pack_data;
  logic flush, slot_free, can_issue;
  logic [3:0] dig_idx;
  logic [7:0] prefix_byte;
  logic [7:0] in_byte;

  assign flush     = (pack_cnt == 4'(adlc_pkg::CHUNK_BYTES)) || pack_final;
  assign slot_free = !chunk_valid || !chunk_stall;
  assign can_issue = gen_active && ((pack_cnt + {3'd0, b_vld}) < 4'(adlc_pkg::CHUNK_BYTES));
  assign rd_addr   = gen_active ? gen_pos[AW-1:0] : cmp_idx;
  assign dig_idx   = field_w - 4'd1 - gen_pos[3:0];
  assign in_byte   = b_mem ? prev_rd : b_byte;

  always_comb begin
    prefix_byte = adlc_pkg::SPACE;
    if (gen_pos[3:0] != field_w && dig_idx < num_digits)
      prefix_byte = adlc_pkg::DIGIT_ZERO + {4'd0, bcd[4*dig_idx +: 4]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_active <= 1'b0;
      b_vld      <= 1'b0;
      phase      <= adlc_pkg::PH_DONE;
    end else if (cmd.emit_start) begin
      gen_active <= 1'b1;
      b_vld      <= 1'b0;
      gen_pos    <= '0;
      emit_last  <= cmd.emit_last;
      phase      <= count_mode ? adlc_pkg::PH_PREFIX : adlc_pkg::PH_LINE;
    end else begin
      b_vld <= can_issue;
      if (can_issue) begin
        b_mem   <= 1'b0;
        b_final <= 1'b0;
        case (phase)
          adlc_pkg::PH_PREFIX: begin
            b_byte <= prefix_byte;
            if (gen_pos[3:0] == field_w) begin
              phase   <= adlc_pkg::PH_LINE;
              gen_pos <= '0;
            end else begin
              gen_pos <= gen_pos + 1'b1;
            end
          end
          adlc_pkg::PH_LINE: begin
            if (gen_pos == PW'(held_len)) begin
              b_byte     <= adlc_pkg::NEWLINE;
              b_final    <= 1'b1;
              gen_active <= 1'b0;
              phase      <= adlc_pkg::PH_DONE;
            end else begin
              b_mem   <= 1'b1;
              gen_pos <= gen_pos + 1'b1;
            end
          end
          default: gen_active <= 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pack_cnt    <= '0;
      pack_final  <= 1'b0;
      chunk_valid <= 1'b0;
    end else begin
      if (chunk_valid && !chunk_stall) chunk_valid <= 1'b0;
      if (cmd.emit_start) begin
        pack_data <= '0;
      end else if (flush && slot_free) begin
        chunk_valid <= 1'b1;
        chunk       <= pack_data;
        chunk_bytes <= pack_cnt;
        line_end    <= pack_final;
        last        <= pack_final && emit_last;
        pack_cnt    <= '0;
        pack_final  <= 1'b0;
        pack_data   <= '0;
      end else if (b_vld) begin
        pack_data[8*pack_cnt[2:0] +: 8] <= in_byte;
        pack_cnt   <= pack_cnt + 1'b1;
        pack_final <= b_final;
      end
    end
  end

  always_comb begin
    st            = '0;
    st.len_eq     = (cur_len == held_len);
    st.cmp_busy   = cmp_active || cmp_pend;
    st.cmp_equal  = !cmp_diff;
    st.conv_done  = conv_done;
    st.emit_busy  = gen_active || b_vld || (pack_cnt != 4'd0);
    st.seen       = seen;
    st.cur_len_nz = (cur_len != '0);
    st.count_mode = count_mode;
  end

  a_pack_bound: assert property (@(posedge clk) disable iff (rst)
    pack_cnt <= 4'(adlc_pkg::CHUNK_BYTES))
    else $error("packer overfilled");

  a_no_append_on_flush: assert property (@(posedge clk) disable iff (rst)
    b_vld |-> (pack_cnt < 4'(adlc_pkg::CHUNK_BYTES) && !pack_final))
    else $error("byte arrived while chunk awaits flush");

  a_chunk_len: assert property (@(posedge clk) disable iff (rst)
    chunk_valid |-> (chunk_bytes != 4'd0 && chunk_bytes <= 4'(adlc_pkg::CHUNK_BYTES)))
    else $error("bad chunk length");

  a_cmp_gen_excl: assert property (@(posedge clk) disable iff (rst)
    !(gen_active && cmp_active))
    else $error("compare and emission share the read port");

endmodule

// ===== design/adjacent_duplicate_line_counter.sv =====
// channel | valid       | stall       | payload
// text    | text_valid  | text_stall  | text_byte, end_of_input
// result  | chunk_valid | chunk_stall | chunk, chunk_bytes, line_end, last
//
// A plain text byte is taken without a stall. A newline compares the line with
// the held one through the line memories when their lengths match. A differing
// line or end of input streams the held line into 8-byte chunks; count mode adds
// a binary-to-decimal conversion before the stream.
// Reset (rst, synchronous) clears control state; line memories are not cleared.
// A stalled result holds the chunk register; the next chunk waits behind it.
module adjacent_duplicate_line_counter #(
  parameter int LINE_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [0:0]  wr_index,
  input  logic [0:0]  wr_data,
  input  logic        text_valid,
  output logic        text_stall,
  input  logic [7:0]  text_byte,
  input  logic        end_of_input,
  output logic        chunk_valid,
  input  logic        chunk_stall,
  output logic [63:0] chunk,
  output logic [3:0]  chunk_bytes,
  output logic        line_end,
  output logic        last
);

  adlc_pkg::cmd_t    cmd;
  adlc_pkg::status_t st;

  adlc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_byte    (text_byte),
    .end_of_input (end_of_input),
    .st           (st),
    .stall        (text_stall),
    .cmd          (cmd)
  );

  adlc_dp #(
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .text_byte   (text_byte),
    .cmd         (cmd),
    .st          (st),
    .chunk_valid (chunk_valid),
    .chunk_stall (chunk_stall),
    .chunk       (chunk),
    .chunk_bytes (chunk_bytes),
    .line_end    (line_end),
    .last        (last)
  );

endmodule

// ===== verif/adlc_checker.sv =====
`timescale 1ns / 1ps

module adlc_checker #(
  parameter int LINE_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [0:0]  wr_index,
  input  logic [0:0]  wr_data,
  input  logic        text_valid,
  input  logic        text_stall,
  input  logic [7:0]  text_byte,
  input  logic        end_of_input,
  input  logic        chunk_valid,
  input  logic        chunk_stall,
  input  logic [63:0] chunk,
  input  logic [3:0]  chunk_bytes,
  input  logic        line_end,
  input  logic        last,
  output int          fails,
  output int          pending,
  output int          chunks_seen
);

  typedef struct {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        le;
    logic        lst;
  } chunk_t;

  chunk_t      want_chunks[$];
  logic        cnt_mode, fold_case;
  logic [7:0]  cur_line[LINE_BYTES];
  logic [7:0]  held_line[LINE_BYTES];
  int unsigned cur_len, held_len;
  logic [31:0] repeats;
  logic        have_line;

  initial begin
    fails = 0;
    chunks_seen = 0;
  end

  always_comb pending = want_chunks.size();

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    fails++;
  endtask

  function automatic logic [7:0] fold(input logic [7:0] c);
    if (fold_case && c >= adlc_pkg::UPPER_A && c <= adlc_pkg::UPPER_Z)
      return c + adlc_pkg::CASE_OFFSET;
    return c;
  endfunction

  function automatic bit same_as_held();
    if (cur_len != held_len) return 0;
    for (int i = 0; i < cur_len; i++)
      if (fold(cur_line[i]) != fold(held_line[i])) return 0;
    return 1;
  endfunction

  task automatic push_held_line();
    logic [7:0]  text[$];
    logic [7:0]  dig[$];
    logic [31:0] c;
    chunk_t      ck;
    int          k;
    if (cnt_mode) begin
      c = repeats;
      do begin
        dig.push_front(adlc_pkg::DIGIT_ZERO + 8'(c % 10));
        c = c / 10;
      end while (c != 0);
      for (int i = dig.size(); i < adlc_pkg::MIN_DIGITS; i++) text.push_back(adlc_pkg::SPACE);
      foreach (dig[i]) text.push_back(dig[i]);
      text.push_back(adlc_pkg::SPACE);
    end
    for (int i = 0; i < held_len; i++) text.push_back(held_line[i]);
    text.push_back(adlc_pkg::NEWLINE);
    for (int off = 0; off < text.size(); off += adlc_pkg::CHUNK_BYTES) begin
      k = text.size() - off;
      if (k > adlc_pkg::CHUNK_BYTES) k = adlc_pkg::CHUNK_BYTES;
      ck.data = '0;
      for (int i = 0; i < k; i++) ck.data[8*i +: 8] = text[off + i];
      ck.nbytes = 4'(k);
      ck.le = (off + k == text.size());
      ck.lst = 0;
      want_chunks.push_back(ck);
    end
  endtask

  task automatic end_line();
    if (!have_line) begin
      held_line = cur_line;
      held_len = cur_len;
      repeats = 1;
      have_line = 1;
    end else if (same_as_held()) begin
      if (repeats != 32'hffff_ffff) repeats++;
    end else begin
      push_held_line();
      held_line = cur_line;
      held_len = cur_len;
      repeats = 1;
    end
    cur_len = 0;
  endtask

  task automatic take_beat(input logic [7:0] b, input logic eoi);
    int before_n;
    before_n = want_chunks.size();
    if (!eoi) begin
      if (b == adlc_pkg::NEWLINE) end_line();
      else if (cur_len < LINE_BYTES - 1) begin
        cur_line[cur_len] = b;
        cur_len++;
      end
    end else begin
      if (cur_len > 0) end_line();
      if (have_line) push_held_line();
      cur_len = 0;
      held_len = 0;
      repeats = 0;
      have_line = 0;
    end
    if (want_chunks.size() > before_n) want_chunks[$].lst = 1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cnt_mode = 0;
      fold_case = 0;
      cur_len = 0;
      held_len = 0;
      repeats = 0;
      have_line = 0;
      want_chunks.delete();
    end else begin
      if (wr_en) begin
        if (wr_index == adlc_pkg::REG_COUNT_MODE) cnt_mode = wr_data[0];
        else if (wr_index == adlc_pkg::REG_IGNORE_CASE) fold_case = wr_data[0];
      end
      if (chunk_valid && !chunk_stall) begin
        chunk_t ck;
        chunks_seen++;
        if (want_chunks.size() == 0) begin
          report($sformatf("unexpected chunk %h", chunk));
        end else begin
          ck = want_chunks.pop_front();
          if (chunk !== ck.data)
            report($sformatf("chunk %h, want %h", chunk, ck.data));
          if (chunk_bytes !== ck.nbytes)
            report($sformatf("chunk_bytes %0d, want %0d", chunk_bytes, ck.nbytes));
          if (line_end !== ck.le)
            report($sformatf("line_end %b, want %b", line_end, ck.le));
          if (last !== ck.lst)
            report($sformatf("last %b, want %b", last, ck.lst));
        end
      end
      if (text_valid && !text_stall) take_beat(text_byte, end_of_input);
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE = 300;

  logic        clk = 0;
  logic        rst = 1;
  logic        wr_en = 0;
  logic [0:0]  wr_index = '0;
  logic [0:0]  wr_data = '0;
  logic        text_valid = 0;
  logic        text_stall;
  logic [7:0]  text_byte = '0;
  logic        end_of_input = 0;
  logic        chunk_valid;
  logic        chunk_stall = 0;
  logic [63:0] chunk;
  logic [3:0]  chunk_bytes;
  logic        line_end;
  logic        last;
  int          fails, pending, chunks_seen;
  int          beats_sent = 0;
  int          idle_cycles = 0;
  bit          calm = 0;
  logic [7:0]  last_line[$];

  always #10 clk = ~clk;

  adjacent_duplicate_line_counter uut (.*);

  adlc_checker chk (.*);

  always @(posedge clk) begin
    if ((text_valid && !text_stall) || (chunk_valid && !chunk_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // result side: random stall before each beat, none in the calm phase
  initial begin
    int n;
    @(negedge clk);
    forever begin
      n = calm ? 0 : $urandom_range(0, 9);
      if (n > 0) begin
        chunk_stall <= 1;
        repeat (n) @(negedge clk);
      end
      chunk_stall <= 0;
      do @(posedge clk); while (!chunk_valid);
      @(negedge clk);
    end
  end

  task automatic send(input logic [7:0] b, input logic eoi);
    int n;
    n = calm ? 0 : $urandom_range(0, 9);
    if (n > 0) begin
      text_valid <= 0;
      repeat (n) @(negedge clk);
    end
    text_valid <= 1;
    text_byte <= b;
    end_of_input <= eoi;
    do @(posedge clk); while (text_stall);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send(s[i], 0);
  endtask

  task automatic set_reg(input logic [0:0] idx, input logic val);
    wr_en <= 1;
    wr_index <= idx;
    wr_data <= val;
    @(negedge clk);
    wr_en <= 0;
  endtask

  task automatic drain();
    text_valid <= 0;
    wait (pending == 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // mostly short lines from a tiny alphabet so runs and case matches happen
  task automatic random_phase(input int items, input bit with_long);
    int start, r, len;
    logic [7:0] line[$];
    logic [7:0] abc[5];
    abc = '{8'h61, 8'h41, 8'h62, 8'h42, 8'h7a};
    start = beats_sent;
    if (with_long) begin
      for (int i = 0; i < 135; i++) send(8'($urandom_range(32, 126)), 0);
      send(adlc_pkg::NEWLINE, 0);
    end
    while (beats_sent - start < items) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        if (last_line.size() > 0 && $urandom_range(0, 1)) begin
          line = last_line;
          foreach (line[i])
            if ($urandom_range(0, 3) == 0) line[i] = line[i] ^ adlc_pkg::CASE_OFFSET;
        end else begin
          line.delete();
          len = $urandom_range(0, 5);
          repeat (len) line.push_back(abc[$urandom_range(0, 4)]);
        end
        foreach (line[i]) send(line[i], 0);
        send(adlc_pkg::NEWLINE, 0);
        last_line = line;
      end else if (r == 6) begin
        send(8'($urandom_range(0, 255)), 0);
      end else if (r == 7) begin
        send(8'($urandom_range(0, 255)), 1);
      end else begin
        repeat ($urandom_range(1, 3)) send(abc[$urandom_range(0, 4)], 0);
      end
    end
    send(8'($urandom_range(0, 255)), 1);
  endtask

  initial begin
    bit cm[5] = '{1, 0, 1, 0, 1};
    bit ic[5] = '{0, 1, 1, 0, 1};
    repeat (2) @(negedge clk);
    rst <= 0;

    // directed: case variants, empty lines, byte extremes, flushes
    send_text("Ab\naB\naB\n\n\n");
    send(8'hff, 0);
    send(8'h00, 0);
    send(adlc_pkg::NEWLINE, 0);
    send(8'h00, 1);
    send(8'hff, 1);
    send_text("x");
    send(8'h55, 1);
    drain();

    for (int p = 0; p < 5; p++) begin
      set_reg(adlc_pkg::REG_COUNT_MODE, cm[p]);
      set_reg(adlc_pkg::REG_IGNORE_CASE, ic[p]);
      calm = (p == 3);
      random_phase(30, p == 2);
      drain();
    end

    $display("sent %0d text beats over 5 register settings, checked %0d chunks",
             beats_sent, chunks_seen);
    $display("covered long-line truncation, empty lines, case folding and count prefix");
    if (fails == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
